@@ sv/hfr_pkg.sv @@
// hfr_pkg: shared constants, state codes, store request/response types and
// hex decode helpers for the hex frame receiver.
// No dependencies.
package hfr_pkg;

	localparam int BUFFER_CHARS = 64;
	localparam int STORE_DEPTH  = BUFFER_CHARS + 2;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
	localparam int LEN_W        = 8;
	localparam int CMP_W        = LEN_W + 1;
	localparam int PAIR_W       = LEN_W - 1;

	localparam logic [7:0] START_CHAR = 8'h41;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_BODY,
		ST_WAIT_TRIG,
		ST_CHECK,
		ST_EMIT
	} hfr_state_t;

	// write port plus one read request (reads the pair at raddr, raddr+1)
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} hfr_mem_req_t;

	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
	} hfr_mem_rsp_t;

	typedef struct packed {
		logic valid;
		logic is_id;
		logic last;
	} hfr_tx_ctl_t;

	// non-hex characters decode as zero
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

	function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
		return {hex_digit(hi), hex_digit(lo)};
	endfunction

endpackage

@@ sv/hfr_if.sv @@
// hfr_if: valid/ready channel interfaces for received characters and
// decoded bytes. No dependencies.
interface hfr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink (input valid, input in_char, output ready);
endinterface

interface hfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_id;
	logic       last;

	modport source (output valid, output out_byte, output is_id, output last, input ready);
	modport sink (input valid, input out_byte, input is_id, input last, output ready);
endinterface

@@ sv/hfr_store.sv @@
// hfr_store: character store, one write port and a registered read of two
// neighboring entries. Depends on hfr_pkg.
module hfr_store (
	input  logic                clk,
	input  hfr_pkg::hfr_mem_req_t req,
	output hfr_pkg::hfr_mem_rsp_t rsp
);
	import hfr_pkg::*;

	logic [7:0]        mem [STORE_DEPTH];
	logic [ADDR_W-1:0] raddr_nxt;
	hfr_mem_rsp_t      rsp_q;

	assign raddr_nxt = req.raddr + ADDR_W'(1);

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rsp_q.hi <= mem[req.raddr];
			rsp_q.lo <= mem[raddr_nxt];
		end
	end

	assign rsp = rsp_q;

endmodule

@@ sv/hfr_ctrl.sv @@
// hfr_ctrl: frame parser, running sum, checksum compare and readout
// sequencer. Depends on hfr_pkg and hfr_char_if.
module hfr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	hfr_char_if.sink              rx,
	input  logic                  tx_ready,
	output hfr_pkg::hfr_tx_ctl_t  tx_ctl,
	output hfr_pkg::hfr_mem_req_t mem_req,
	input  hfr_pkg::hfr_mem_rsp_t mem_rsp
);
	import hfr_pkg::*;

	hfr_state_t        state_q, state_nxt;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        sum_q;
	logic [3:0]        hi_nib_q;
	logic [PAIR_W-1:0] k_q;
	logic [PAIR_W-1:0] last_pair_q;
	logic              tx_valid_q;
	logic              is_id_q;
	logic              last_q;

	logic              fire;
	logic              emit_go;
	logic [CNT_W-1:0]  cnt_inc;
	logic [LEN_W-1:0]  len_new;
	logic              body_sum_en;
	logic              body_done;
	logic [ADDR_W-1:0] ck_addr;
	logic              pair_match;
	logic [PAIR_W-1:0] last_pair_calc;
	logic              k_is_last;
	logic [LEN_W-1:0]  len_m2;

	assign fire        = rx.valid && rx.ready;
	assign emit_go     = (state_q == ST_EMIT) && (!tx_valid_q || tx_ready);
	assign cnt_inc     = count_q + CNT_W'(1);
	assign len_new     = {hi_nib_q, hex_digit(rx.in_char)};
	assign body_sum_en = CMP_W'(cnt_inc) <= CMP_W'(len_q);
	assign body_done   = CMP_W'(cnt_inc) >= (CMP_W'(len_q) + CMP_W'(2));
	assign ck_addr     = ADDR_W'(count_q - CNT_W'(2));
	assign pair_match  = hex_pair(mem_rsp.hi, mem_rsp.lo) == sum_q;
	assign len_m2      = len_q - LEN_W'(2);
	assign last_pair_calc = (len_q >= LEN_W'(4)) ? len_m2[LEN_W-1:1] : PAIR_W'(1);
	assign k_is_last   = k_q == last_pair_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && rx.in_char == START_CHAR) state_nxt = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				if (fire) state_nxt = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				if (fire) begin
					state_nxt = (CMP_W'(len_new) < CMP_W'(BUFFER_CHARS)) ? ST_BODY : ST_HUNT;
				end
			end
			ST_BODY: begin
				if (fire && body_done) state_nxt = ST_WAIT_TRIG;
			end
			ST_WAIT_TRIG: begin
				if (fire) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				state_nxt = pair_match ? ST_EMIT : ST_HUNT;
			end
			ST_EMIT: begin
				if (emit_go && k_is_last) state_nxt = ST_HUNT;
			end
			default: state_nxt = ST_HUNT;
		endcase
	end

	// outputs: input ready and store access
	always_comb begin
		rx.ready      = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = count_q[ADDR_W-1:0];
		mem_req.wdata = rx.in_char;
		mem_req.re    = emit_go;
		mem_req.raddr = emit_go ? ADDR_W'({k_q, 1'b0}) : ck_addr;
		unique case (state_q)
			ST_HUNT: begin
				rx.ready = 1'b1;
			end
			ST_LEN_HI, ST_LEN_LO, ST_BODY: begin
				rx.ready   = 1'b1;
				mem_req.we = fire;
			end
			ST_WAIT_TRIG: begin
				// read regs double as the output stage: wait until it drains
				rx.ready   = !tx_valid_q;
				mem_req.re = fire;
			end
			ST_CHECK, ST_EMIT: begin
				rx.ready = 1'b0;
			end
			default: rx.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_HUNT;
			count_q     <= '0;
			len_q       <= '0;
			sum_q       <= '0;
			hi_nib_q    <= '0;
			k_q         <= '0;
			last_pair_q <= '0;
			tx_valid_q  <= 1'b0;
			is_id_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_HUNT: begin
					if (fire && rx.in_char == START_CHAR) begin
						count_q <= '0;
						sum_q   <= '0;
					end
				end
				ST_LEN_HI: begin
					if (fire) begin
						count_q  <= cnt_inc;
						sum_q    <= sum_q + rx.in_char;
						hi_nib_q <= hex_digit(rx.in_char);
					end
				end
				ST_LEN_LO: begin
					if (fire) begin
						count_q <= cnt_inc;
						sum_q   <= sum_q + rx.in_char;
						len_q   <= len_new;
					end
				end
				ST_BODY: begin
					if (fire) begin
						count_q <= cnt_inc;
						if (body_sum_en) sum_q <= sum_q + rx.in_char;
					end
				end
				ST_CHECK: begin
					k_q         <= PAIR_W'(1);
					last_pair_q <= last_pair_calc;
				end
				ST_EMIT: begin
					if (emit_go) k_q <= k_q + PAIR_W'(1);
				end
				ST_WAIT_TRIG: begin
				end
				default: begin
				end
			endcase

			if (emit_go) begin
				tx_valid_q <= 1'b1;
				is_id_q    <= k_q == PAIR_W'(1);
				last_q     <= k_is_last;
			end else if (tx_ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	assign tx_ctl.valid = tx_valid_q;
	assign tx_ctl.is_id = is_id_q;
	assign tx_ctl.last  = last_q;

endmodule

@@ sv/hex_frame_receiver.sv @@
// hex_frame_receiver: top level; ties the frame controller to the character
// store. Depends on hfr_pkg, hfr_if, hfr_ctrl and hfr_store.
//
// Receives hex-coded frames one ASCII character per item on rx and emits
// the decoded message id and data bytes on tx. While hunting, 'A' opens a
// frame and every other character is dropped. Two hex characters give the
// length L; L of BUFFER_CHARS or more aborts the frame. L more characters
// are stored (at least one), the last two being the hex checksum of the
// 8-bit sum over the length characters and the stored characters up to
// position L. The next character is the trigger: it is consumed, never
// stored, and starts the check. On a match the id byte (is_id = 1) comes
// out first, then one byte per hex pair, the final one with last = 1; on a
// mismatch nothing comes out. Rate: one character per cycle while a frame
// is being received. After the trigger, the checksum is read from the
// store and compared, then the decoded bytes ((L-2)/2 of them, at least
// one) follow back to back as long as tx keeps taking them; rx is held
// off during that readout. The store reads one pair of neighboring
// characters per cycle into a read register, and that register is the
// tx output stage, so a trigger waits until the previous frame's last
// byte has been taken. Characters of a new frame are still taken while
// that byte waits. The store needs no clearing pass after reset.
module hex_frame_receiver (
	input  logic       clk,
	input  logic       arst_n,
	hfr_char_if.sink   rx,
	hfr_byte_if.source tx
);
	import hfr_pkg::*;

	hfr_mem_req_t mem_req;
	hfr_mem_rsp_t mem_rsp;
	hfr_tx_ctl_t  tx_ctl;

	hfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.tx_ready(tx.ready),
		.tx_ctl  (tx_ctl),
		.mem_req (mem_req),
		.mem_rsp (mem_rsp)
	);

	hfr_store u_store (
		.clk(clk),
		.req(mem_req),
		.rsp(mem_rsp)
	);

	// the store's read register holds the pair; decode it on the way out
	assign tx.valid    = tx_ctl.valid;
	assign tx.is_id    = tx_ctl.is_id;
	assign tx.last     = tx_ctl.last;
	assign tx.out_byte = hex_pair(mem_rsp.hi, mem_rsp.lo);

endmodule

@@ sv/hfr_checker.sv @@
// hfr_checker: port-level assertions for the hex frame receiver, bound to
// the top level. No package dependencies.
module hfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] out_byte,
	input logic       is_id,
	input logic       last
);

	// stalled result holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(out_byte) && $stable(is_id)
			&& $stable(last))
		else $error("tx item changed while stalled");

	// a run is contiguous: after a non-final byte is taken the next is ready
	a_run_contig: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && !last |=> tx_valid && !is_id)
		else $error("run broken or id byte inside a run");

	// every run opens with the id byte
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tx_valid) |-> is_id)
		else $error("run did not start with id byte");

	// no characters taken in the middle of a run
	a_rx_block: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !last |-> !rx_ready)
		else $error("input taken during readout");

endmodule

bind hex_frame_receiver hfr_checker u_hfr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.rx_ready(rx.ready),
	.tx_valid(tx.valid),
	.tx_ready(tx.ready),
	.out_byte(tx.out_byte),
	.is_id   (tx.is_id),
	.last    (tx.last)
);
